/* hdl/rfc_pkg.sv */
// Shared types, codes and helper functions for the response frame checker.
// No dependencies; imported by every module of the block.
package rfc_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_CRC_SEED = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CRC_POLY = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CMD_MARK = 2'd2;

  localparam logic [7:0] CRC_SEED_RST = 8'hAA;
  localparam logic [7:0] CRC_POLY_RST = 8'hA6;
  localparam logic [7:0] CMD_MARK_RST = 8'hC0;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic TYPE_RESPONSE = 1'b0;
  localparam logic TYPE_COMMAND  = 1'b1;

  localparam logic [1:0] VERDICT_GOOD   = 2'd0;
  localparam logic [1:0] VERDICT_CRC    = 2'd1;
  localparam logic [1:0] VERDICT_STATUS = 2'd2;

  localparam logic [3:0] STATUS_OK          = 4'd0;
  localparam logic [3:0] STATUS_HARDWARE    = 4'd8;
  localparam logic [3:0] STATUS_NOT_READY   = 4'd9;
  localparam logic [3:0] STATUS_HAND_RAISED = 4'd10;
  localparam logic [3:0] STATUS_UNKNOWN     = 4'd11;

  localparam logic [7:0] STAT_BIT_HW    = 8'h08;
  localparam logic [7:0] STAT_BIT_NRDY  = 8'h10;
  localparam logic [7:0] STAT_BIT_HAND  = 8'h20;
  localparam logic [7:0] STAT_EXACT_MAX = 8'd7;

  localparam logic [8:0] HDR_LEN_RSP = 9'd2;
  localparam logic [8:0] HDR_LEN_CMD = 9'd3;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic       frame_type;
    logic [7:0] command_code;
    logic [7:0] payload_length;
    logic [3:0] device_status;
    logic [1:0] verdict;
    logic       last_of_frame;
  } result_t;

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data,
                                           logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [3:0] status_decode(logic [7:0] s);
    logic [3:0] code;
    if (s <= STAT_EXACT_MAX) begin
      code = s[3:0];
    end else if ((s & STAT_BIT_HW) != 8'd0) begin
      code = STATUS_HARDWARE;
    end else if ((s & STAT_BIT_NRDY) != 8'd0) begin
      code = STATUS_NOT_READY;
    end else if ((s & STAT_BIT_HAND) != 8'd0) begin
      code = STATUS_HAND_RAISED;
    end else begin
      code = STATUS_UNKNOWN;
    end
    return code;
  endfunction

endpackage

/* hdl/rfc_parser.sv */
// Frame parser: configuration registers, frame state, CRC-8 and result build.
// Depends on rfc_pkg.
module rfc_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          frame_start_i,
  input  logic                          cfg_we_i,
  input  logic [rfc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [7:0]                    cfg_wdata_i,
  output logic                          res_valid_o,
  output rfc_pkg::result_t              res_o
);
  import rfc_pkg::*;

  logic [7:0] crc_seed_q, crc_poly_q, cmd_mark_q;
  logic       in_frame_q, in_frame_d;
  logic [8:0] pos_q, pos_d;
  logic       is_cmd_q, is_cmd_d;
  logic [7:0] len_q, len_d;
  logic [7:0] crc_q, crc_d;
  logic [3:0] status_q, status_d;
  logic [7:0] cmd_q, cmd_d;

  logic       start;
  logic [7:0] crc_next;
  logic [8:0] hdr;
  logic [8:0] pay_end;
  logic [8:0] pay_idx;
  logic       emit;

  assign start    = frame_start_i || !in_frame_q;
  assign crc_next = crc8_byte(start ? crc_seed_q : crc_q, rx_byte_i, crc_poly_q);
  assign hdr      = is_cmd_q ? HDR_LEN_CMD : HDR_LEN_RSP;
  assign pay_end  = hdr + {1'b0, len_q};
  assign pay_idx  = pos_q - hdr;

  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    is_cmd_d   = is_cmd_q;
    len_d      = len_q;
    crc_d      = crc_q;
    status_d   = status_q;
    cmd_d      = cmd_q;
    emit       = 1'b0;

    res_o.result_kind    = KIND_PAYLOAD;
    res_o.payload_byte   = 8'd0;
    res_o.byte_index     = 8'd0;
    res_o.frame_type     = is_cmd_q;
    res_o.command_code   = is_cmd_q ? cmd_q : 8'd0;
    res_o.payload_length = len_q;
    res_o.device_status  = status_q;
    res_o.verdict        = VERDICT_GOOD;
    res_o.last_of_frame  = 1'b0;

    if (start) begin
      crc_d      = crc_next;
      in_frame_d = 1'b1;
      pos_d      = 9'd1;
      len_d      = 8'd0;
      cmd_d      = 8'd0;
      if (rx_byte_i == cmd_mark_q) begin
        is_cmd_d = TYPE_COMMAND;
        status_d = STATUS_OK;
      end else begin
        is_cmd_d = TYPE_RESPONSE;
        status_d = status_decode(rx_byte_i);
      end
    end else if (pos_q < hdr) begin
      crc_d = crc_next;
      if (pos_q == hdr - 9'd1) begin
        len_d = rx_byte_i;
      end else begin
        cmd_d = rx_byte_i;
      end
      pos_d = pos_q + 9'd1;
    end else if (pos_q < pay_end) begin
      crc_d              = crc_next;
      emit               = 1'b1;
      res_o.payload_byte = rx_byte_i;
      res_o.byte_index   = pay_idx[7:0];
      pos_d              = pos_q + 9'd1;
    end else begin
      emit                = 1'b1;
      res_o.result_kind   = KIND_VERDICT;
      res_o.last_of_frame = 1'b1;
      if (crc_q != rx_byte_i) begin
        res_o.verdict = VERDICT_CRC;
      end else if (status_q != STATUS_OK) begin
        res_o.verdict = VERDICT_STATUS;
      end else begin
        res_o.verdict = VERDICT_GOOD;
      end
      in_frame_d = 1'b0;
      pos_d      = 9'd0;
    end
  end

  assign res_valid_o = accept_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_seed_q <= CRC_SEED_RST;
      crc_poly_q <= CRC_POLY_RST;
      cmd_mark_q <= CMD_MARK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CRC_SEED: crc_seed_q <= cfg_wdata_i;
        CFG_CRC_POLY: crc_poly_q <= cfg_wdata_i;
        CFG_CMD_MARK: cmd_mark_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= 9'd0;
      is_cmd_q   <= 1'b0;
      len_q      <= 8'd0;
      crc_q      <= CRC_SEED_RST;
      status_q   <= STATUS_OK;
      cmd_q      <= 8'd0;
    end else if (accept_i) begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      is_cmd_q   <= is_cmd_d;
      len_q      <= len_d;
      crc_q      <= crc_d;
      status_q   <= status_d;
      cmd_q      <= cmd_d;
    end
  end

endmodule

/* hdl/rfc_out_buf.sv */
// Result register with one skid entry between the parser and the output channel.
// Depends on rfc_pkg.
module rfc_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rfc_pkg::result_t push_data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rfc_pkg::result_t out_data_o
);
  import rfc_pkg::*;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

endmodule

/* hdl/response_frame_checker.sv */
// Response frame checker top level: frame parser with CRC-8 check, result buffer.
// Depends on rfc_pkg, rfc_parser and rfc_out_buf.
//
//   channel | handshake                  | payload
//   --------+----------------------------+------------------------------------------
//   request | in_valid_i / in_stall_o    | rx_byte_i, frame_start_i
//   result  | out_valid_o / out_stall_i  | result_kind_o .. last_of_frame_o
//   config  | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//
// One request per cycle unless in_stall_o is high; each result is registered.
// The CRC-8 byte step and the frame counters are computed combinationally.
// in_stall_o rises only when the result register and its skid entry are both full.
// Reset clears frame state and loads seed 0xAA, polynomial 0xA6, marker 0xC0.
module response_frame_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        frame_start_i,
  input  logic                        cfg_we_i,
  input  logic [rfc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                  cfg_wdata_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        result_kind_o,
  output logic [7:0]                  payload_byte_o,
  output logic [7:0]                  byte_index_o,
  output logic                        frame_type_o,
  output logic [7:0]                  command_code_o,
  output logic [7:0]                  payload_length_o,
  output logic [3:0]                  device_status_o,
  output logic [1:0]                  verdict_o,
  output logic                        last_of_frame_o
);
  import rfc_pkg::*;

  logic    accept;
  logic    res_valid;
  logic    buf_full;
  result_t res;
  result_t out_data;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  rfc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .rx_byte_i    (rx_byte_i),
    .frame_start_i(frame_start_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  rfc_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  assign result_kind_o    = out_data.result_kind;
  assign payload_byte_o   = out_data.payload_byte;
  assign byte_index_o     = out_data.byte_index;
  assign frame_type_o     = out_data.frame_type;
  assign command_code_o   = out_data.command_code;
  assign payload_length_o = out_data.payload_length;
  assign device_status_o  = out_data.device_status;
  assign verdict_o        = out_data.verdict;
  assign last_of_frame_o  = out_data.last_of_frame;

endmodule

/* tb/response_frame_checker_test.sv */
// Self-checking bench for response_frame_checker: streams frames of serial bytes, predicts
// the payload and verdict results of each frame, and compares them with what the block emits.
// Depends on rfc_pkg and the response_frame_checker RTL.
module response_frame_checker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rfc_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned LONG_HOLD = 200;
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct {
    logic [7:0] rx_byte;
    logic       frame_start;
  } rx_req_t;

  typedef enum int {STALL_NONE, STALL_SOME, STALL_TOGGLE, STALL_HEAVY} stall_style_e;

  class frame_tracker;
    logic [7:0]  seed;
    logic [7:0]  poly;
    logic [7:0]  marker;
    bit          open;
    int unsigned pos;
    bit          is_cmd;
    logic [7:0]  len;
    logic [7:0]  crc;
    logic [3:0]  status;
    logic [7:0]  cmd;
    result_t     results_due[$];
    int unsigned mismatches;

    function new();
      seed = CRC_SEED_RST;
      poly = CRC_POLY_RST;
      marker = CMD_MARK_RST;
      open = 1'b0;
      pos = 0;
      is_cmd = 1'b0;
      len = 8'd0;
      crc = CRC_SEED_RST;
      status = STATUS_OK;
      cmd = 8'd0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] v);
      case (idx)
        CFG_CRC_SEED: seed = v;
        CFG_CRC_POLY: poly = v;
        CFG_CMD_MARK: marker = v;
        default: ;
      endcase
    endfunction

    function logic [7:0] crc_byte(logic [7:0] acc, logic [7:0] data);
      logic [7:0] r;
      logic       msb;
      r = acc ^ data;
      repeat (8) begin
        msb = r[7];
        r = r << 1;
        if (msb) r = r ^ poly;
      end
      return r;
    endfunction

    function logic [3:0] status_of(logic [7:0] s);
      if (s <= STAT_EXACT_MAX) return s[3:0];
      if (s[3]) return STATUS_HARDWARE;
      if (s[4]) return STATUS_NOT_READY;
      if (s[5]) return STATUS_HAND_RAISED;
      return STATUS_UNKNOWN;
    endfunction

    function void take_byte(logic [7:0] b, logic start);
      int unsigned hdr;
      result_t     r;
      if (start || !open) begin
        crc = crc_byte(seed, b);
        open = 1'b1;
        pos = 1;
        len = 8'd0;
        cmd = 8'd0;
        is_cmd = (b == marker);
        status = is_cmd ? STATUS_OK : status_of(b);
        return;
      end
      hdr = is_cmd ? HDR_LEN_CMD : HDR_LEN_RSP;
      if (pos < hdr) begin
        crc = crc_byte(crc, b);
        if (pos == hdr - 1) len = b;
        else cmd = b;
        pos++;
        return;
      end
      r = '0;
      r.frame_type = is_cmd ? TYPE_COMMAND : TYPE_RESPONSE;
      r.command_code = is_cmd ? cmd : 8'd0;
      r.payload_length = len;
      r.device_status = status;
      if (pos < hdr + len) begin
        crc = crc_byte(crc, b);
        r.result_kind = KIND_PAYLOAD;
        r.payload_byte = b;
        r.byte_index = 8'(pos - hdr);
        r.verdict = VERDICT_GOOD;
        r.last_of_frame = 1'b0;
        pos++;
      end else begin
        r.result_kind = KIND_VERDICT;
        if (crc != b) r.verdict = VERDICT_CRC;
        else if (status != STATUS_OK) r.verdict = VERDICT_STATUS;
        else r.verdict = VERDICT_GOOD;
        r.last_of_frame = 1'b1;
        open = 1'b0;
        pos = 0;
      end
      results_due.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        mismatches++;
      end
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        $error("result with nothing pending: kind %0d verdict %0d", got.result_kind,
               got.verdict);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      check_field("result_kind", want.result_kind, got.result_kind);
      check_field("payload_byte", want.payload_byte, got.payload_byte);
      check_field("byte_index", want.byte_index, got.byte_index);
      check_field("frame_type", want.frame_type, got.frame_type);
      check_field("command_code", want.command_code, got.command_code);
      check_field("payload_length", want.payload_length, got.payload_length);
      check_field("device_status", want.device_status, got.device_status);
      check_field("verdict", want.verdict, got.verdict);
      check_field("last_of_frame", want.last_of_frame, got.last_of_frame);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i = 8'd0;
  logic               frame_start_i = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CFG_CRC_SEED;
  logic [7:0]         cfg_wdata_i = 8'd0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               result_kind_o;
  logic [7:0]         payload_byte_o;
  logic [7:0]         byte_index_o;
  logic               frame_type_o;
  logic [7:0]         command_code_o;
  logic [7:0]         payload_length_o;
  logic [3:0]         device_status_o;
  logic [1:0]         verdict_o;
  logic               last_of_frame_o;

  frame_tracker board;
  rx_req_t      rx_q[$];
  bit           gen_open = 1'b0;
  int unsigned  hold_asks = 0;
  int unsigned  holds_served = 0;
  int unsigned  hold_left = 0;
  stall_style_e stall_mode = STALL_NONE;
  int unsigned  mode_left = 0;

  response_frame_checker i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .frame_start_i    (frame_start_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .payload_byte_o   (payload_byte_o),
    .byte_index_o     (byte_index_o),
    .frame_type_o     (frame_type_o),
    .command_code_o   (command_code_o),
    .payload_length_o (payload_length_o),
    .device_status_o  (device_status_o),
    .verdict_o        (verdict_o),
    .last_of_frame_o  (last_of_frame_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void queue_byte(logic [7:0] b, logic s);
    rx_req_t r;
    r.rx_byte = b;
    r.frame_start = s;
    rx_q.push_back(r);
  endfunction

  function automatic void add_frame(logic [7:0] head, logic [7:0] cmd, logic [7:0] len,
                                    bit bad_crc, bit truncate);
    logic [7:0]  body[$];
    logic [7:0]  crc;
    int unsigned keep;
    body.push_back(head);
    if (head == board.marker) body.push_back(cmd);
    body.push_back(len);
    repeat (len) body.push_back(8'($urandom));
    crc = board.seed;
    foreach (body[i]) crc = board.crc_byte(crc, body[i]);
    if (bad_crc) crc ^= 8'($urandom_range(1, 255));
    keep = truncate ? $urandom_range(1, body.size()) : body.size();
    for (int i = 0; i < keep; i++) begin
      queue_byte(body[i], (i == 0) && (gen_open || $urandom_range(0, 1) == 1));
    end
    if (truncate) begin
      gen_open = 1'b1;
    end else begin
      queue_byte(crc, 1'b0);
      gen_open = 1'b0;
    end
  endfunction

  function automatic logic [7:0] head_byte();
    case ($urandom_range(0, 2))
      0: return board.marker;
      1: return 8'($urandom_range(0, 7));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] payload_len();
    if ($urandom_range(0, 9) < 8) return 8'($urandom_range(0, 6));
    return 8'($urandom_range(7, 40));
  endfunction

  function automatic void fill_random(int unsigned target);
    int unsigned pick;
    while (rx_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        add_frame(head_byte(), 8'($urandom), payload_len(), $urandom_range(0, 6) == 0, 1'b0);
      end else if (pick < 86) begin
        add_frame(head_byte(), 8'($urandom), payload_len(), 1'b0, 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom), $urandom_range(0, 3) == 0);
        gen_open = 1'b1;
      end
    end
  endfunction

  task automatic send_all();
    int unsigned burst_left;
    int unsigned gap_left;
    burst_left = $urandom_range(1, 30);
    gap_left = 0;
    while (rx_q.size() != 0) begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) begin
        board.take_byte(rx_q[0].rx_byte, rx_q[0].frame_start);
        void'(rx_q.pop_front());
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else if (!in_valid_i && gap_left != 0) begin
        gap_left--;
      end
      if (rx_q.size() != 0 && gap_left == 0) begin
        in_valid_i <= 1'b1;
        rx_byte_i <= rx_q[0].rx_byte;
        frame_start_i <= rx_q[0].frame_start;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    board.write_reg(idx, v);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    while (board.results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      board.match_result({result_kind_o, payload_byte_o, byte_index_o, frame_type_o,
                          command_code_o, payload_length_o, device_status_o, verdict_o,
                          last_of_frame_o});
    end
    if (holds_served != hold_asks) begin
      holds_served = hold_asks;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_style_e'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE: out_stall_i <= 1'b0;
        STALL_SOME: out_stall_i <= ($urandom_range(0, 2) == 0);
        STALL_TOGGLE: out_stall_i <= ~out_stall_i;
        default: out_stall_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : sequencer
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // status ok, command frame, crc error over error status, error status, forced restart, unknown status, exact status
    add_frame(8'h00, 8'h00, 8'd0, 1'b0, 1'b0);
    add_frame(CMD_MARK_RST, 8'hFF, 8'd2, 1'b0, 1'b0);
    add_frame(8'h08, 8'h00, 8'd1, 1'b1, 1'b0);
    add_frame(8'h10, 8'h00, 8'd0, 1'b0, 1'b0);
    queue_byte(8'h20, 1'b1);
    queue_byte(8'h03, 1'b0);
    queue_byte(8'h11, 1'b0);
    gen_open = 1'b1;
    add_frame(8'h40, 8'h00, 8'd0, 1'b0, 1'b0);
    add_frame(8'h07, 8'h00, 8'd1, 1'b0, 1'b0);
    send_all();
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: add_frame(head_byte(), 8'($urandom), 8'd255, 1'b0, 1'b0);
        1: begin
          write_reg(CFG_CRC_SEED, 8'h00);
          write_reg(CFG_CRC_POLY, 8'h00);
          write_reg(CFG_CMD_MARK, 8'h00);
          write_reg(CFG_UNUSED, 8'($urandom));
        end
        2: begin
          write_reg(CFG_CRC_SEED, 8'hFF);
          write_reg(CFG_CRC_POLY, 8'hFF);
          write_reg(CFG_CMD_MARK, 8'hFF);
          hold_asks++;
        end
        default: begin
          write_reg(CFG_CRC_POLY, 8'($urandom));
          write_reg(CFG_CRC_SEED, 8'($urandom));
          write_reg(CFG_CMD_MARK, 8'($urandom));
        end
      endcase
      fill_random(rx_q.size() + 30);
      send_all();
      settle();
    end

    if (board.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
